// ===== rtl/coordinate_set_table_assert.svh =====
// ----------------------------------------------------------------------------
// coordinate set table assertion macros
// shared property wrappers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef COORDINATE_SET_TABLE_ASSERT_SVH
`define COORDINATE_SET_TABLE_ASSERT_SVH

// property must hold at every enabled clock edge
`define CST_ASSERT_PROP(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("coordinate set table check failed");

// expression must never be true
`define CST_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("coordinate set table check failed");

`endif

// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// types and constants shared by the coordinate set table modules
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    localparam int COORD_W = 9;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t EMPTY_MARK = '1;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_QUERY  = 2'd3
    } req_type_t;

endpackage

`default_nettype wire

// ===== rtl/cst_first_set.sv =====
// ----------------------------------------------------------------------------
// cst_first_set
// priority encoder: index of the lowest set bit of a slot mask
// ----------------------------------------------------------------------------
`default_nettype none

module cst_first_set #(
    parameter int N     = 16,
    parameter int IDX_W = (N > 1) ? $clog2(N) : 1
) (
    input  logic [N-1:0]     mask,
    output logic             found,
    output logic [IDX_W-1:0] index
);

    always_comb
    begin
        found = |mask;
        index = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                index = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/coordinate_set_table.sv =====
// ----------------------------------------------------------------------------
// coordinate_set_table
// set of (x,y) slots with add, remove, clear and query; (-1,-1) marks empty
// ----------------------------------------------------------------------------
// channel   handshake                   payload
// request   start in, busy out          req_type, req_x, req_y
// result    done out (one-cycle strobe) was_present, stored, table_empty,
//                                       first_found, first_x, first_y
//
// one item per cycle; busy stays low, so start may be high every cycle
// an accepted item passes req_valid_reg and then done_reg; its result shows with done
// slot compares and lowest-slot searches are combinational; the slot update is registered
// rst_n empties every slot at once
// the receiver cannot stall; done is never held off
// ----------------------------------------------------------------------------
`default_nettype none

module coordinate_set_table #(
    parameter int SLOT_COUNT = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      req_type,
    input  cst_pkg::coord_t req_x,
    input  cst_pkg::coord_t req_y,
    output logic            done,
    output logic            was_present,
    output logic            stored,
    output logic            table_empty,
    output logic            first_found,
    output cst_pkg::coord_t first_x,
    output cst_pkg::coord_t first_y
);

    import cst_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic      req_valid_reg;
    req_type_t req_type_reg;
    coord_t    req_x_reg;
    coord_t    req_y_reg;

    coord_t slot_x_reg [SLOT_COUNT];
    coord_t slot_y_reg [SLOT_COUNT];

    logic done_reg;
    logic was_present_reg;
    logic stored_reg;

    logic [SLOT_COUNT-1:0] match_mask;
    logic [SLOT_COUNT-1:0] empty_mask;
    logic                  hit_found;
    logic [IDX_W-1:0]      hit_idx;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic                  occ_found;
    logic [IDX_W-1:0]      occ_idx;
    logic                  do_add;
    logic                  do_remove;
    logic                  do_clear;

    assign busy = 1'b0;

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            match_mask[i] = (slot_x_reg[i] == req_x_reg) && (slot_y_reg[i] == req_y_reg);
            empty_mask[i] = (slot_x_reg[i] == EMPTY_MARK) && (slot_y_reg[i] == EMPTY_MARK);
        end
    end

    cst_first_set #(.N(SLOT_COUNT), .IDX_W(IDX_W)) u_hit (
        .mask  (match_mask),
        .found (hit_found),
        .index (hit_idx)
    );

    cst_first_set #(.N(SLOT_COUNT), .IDX_W(IDX_W)) u_free (
        .mask  (empty_mask),
        .found (free_found),
        .index (free_idx)
    );

    cst_first_set #(.N(SLOT_COUNT), .IDX_W(IDX_W)) u_first (
        .mask  (~empty_mask),
        .found (occ_found),
        .index (occ_idx)
    );

    always_comb
    begin
        do_add    = 1'b0;
        do_remove = 1'b0;
        do_clear  = 1'b0;
        unique case (req_type_reg)
            REQ_ADD:    do_add    = req_valid_reg && !hit_found && free_found;
            REQ_REMOVE: do_remove = req_valid_reg && hit_found;
            REQ_CLEAR:  do_clear  = req_valid_reg;
            REQ_QUERY:  ;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_x_reg[i] <= EMPTY_MARK;
                slot_y_reg[i] <= EMPTY_MARK;
            end
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (do_clear || (do_remove && (hit_idx == IDX_W'(i))))
                begin
                    slot_x_reg[i] <= EMPTY_MARK;
                    slot_y_reg[i] <= EMPTY_MARK;
                end
                else if (do_add && (free_idx == IDX_W'(i)))
                begin
                    slot_x_reg[i] <= req_x_reg;
                    slot_y_reg[i] <= req_y_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_type_reg <= req_type_t'(req_type);
            req_x_reg    <= req_x;
            req_y_reg    <= req_y;
        end
        was_present_reg <= hit_found;
        stored_reg      <= do_add;
    end

    // slots already hold the post-operation contents during the done cycle
    assign done        = done_reg;
    assign was_present = was_present_reg;
    assign stored      = stored_reg;
    assign table_empty = !occ_found;
    assign first_found = occ_found;
    assign first_x     = occ_found ? slot_x_reg[occ_idx] : EMPTY_MARK;
    assign first_y     = occ_found ? slot_y_reg[occ_idx] : EMPTY_MARK;

endmodule

`default_nettype wire

// ===== rtl/cst_checker.sv =====
// ----------------------------------------------------------------------------
// cst_checker
// port-level checks on the coordinate set table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "coordinate_set_table_assert.svh"

module cst_checker (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire                  busy,
    input  wire                  done,
    input  wire                  was_present,
    input  wire                  stored,
    input  wire                  table_empty,
    input  wire                  first_found,
    input  wire cst_pkg::coord_t first_x,
    input  wire cst_pkg::coord_t first_y
);

    import cst_pkg::*;

    `CST_ASSERT_PROP(a_item_gives_result, (start && !busy) |-> ##2 done)
    `CST_ASSERT_PROP(a_result_has_item, done |-> $past(start && !busy, 2))
    `CST_ASSERT_PROP(a_empty_flags_agree, done |-> (table_empty != first_found))
    `CST_ASSERT_PROP(a_stored_new_item, (done && stored) |-> (!was_present && first_found))
    `CST_ASSERT_PROP(a_empty_reads_mark,
        (done && table_empty) |-> ((first_x == EMPTY_MARK) && (first_y == EMPTY_MARK)))

endmodule

bind coordinate_set_table cst_checker u_cst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .was_present (was_present),
    .stored      (stored),
    .table_empty (table_empty),
    .first_found (first_found),
    .first_x     (first_x),
    .first_y     (first_y)
);

`default_nettype wire
